/* hdl/urb_pkg.sv */
// ----------------------------------------------------------------------------
// urb_pkg
// types, depths and command codes shared by the uart ring buffer unit
// ----------------------------------------------------------------------------
package urb_pkg;

   localparam int RX_DEPTH = 64;
   localparam int TX_DEPTH = 64;
   localparam int RX_PTR_W = (RX_DEPTH > 2) ? $clog2(RX_DEPTH) : 1;
   localparam int TX_PTR_W = (TX_DEPTH > 2) ? $clog2(TX_DEPTH) : 1;

   localparam logic [2:0] CMD_LINE_RX    = 3'd0;
   localparam logic [2:0] CMD_READ       = 3'd1;
   localparam logic [2:0] CMD_PUT_START  = 3'd2;
   localparam logic [2:0] CMD_QUEUE      = 3'd3;
   localparam logic [2:0] CMD_START_TX   = 3'd4;
   localparam logic [2:0] CMD_LINE_READY = 3'd5;
   localparam logic [2:0] CMD_FLUSH_RX   = 3'd6;

   localparam logic [2:0] ERR_NONE     = 3'b000;
   localparam logic [2:0] ERR_OVERFLOW = 3'b100;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] in_byte;
      logic       in_frame_error;
      logic       in_overrun;
   } urb_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       no_data;
      logic       err_frame;
      logic       err_overrun;
      logic       err_overflow;
      logic       accepted;
      logic       rx_available;
      logic       tx_pending;
      logic       tx_enabled;
   } urb_rsp_type;

   // result fields known at accept time, plus where the byte comes from
   typedef struct packed {
      logic        from_rx;
      logic        from_tx;
      urb_rsp_type rsp;
   } urb_stage_type;

endpackage

/* hdl/urb_ram.sv */
// ----------------------------------------------------------------------------
// urb_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module urb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/urb_ctrl.sv */
// ----------------------------------------------------------------------------
// urb_ctrl
// command decode, ring pointers, error and tx enable state, both ring stores
// ----------------------------------------------------------------------------
module urb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  urb_pkg::urb_req_type  req,
   output urb_pkg::urb_stage_type stage,
   output logic [7:0]            rx_rdata,
   output logic [7:0]            tx_rdata
);
   import urb_pkg::*;

   logic [RX_PTR_W-1:0] rx_wr_ff, rx_wr_in, rx_rd_ff, rx_rd_in;
   logic [TX_PTR_W-1:0] tx_wr_ff, tx_wr_in, tx_rd_ff, tx_rd_in;
   logic [2:0]          last_err_ff, last_err_in;
   logic                tx_en_ff, tx_en_in;

   logic [RX_PTR_W-1:0] rx_wr_nxt, rx_rd_nxt;
   logic [TX_PTR_W-1:0] tx_wr_nxt, tx_rd_nxt;
   logic                rx_full, rx_empty, tx_full, tx_empty;
   logic                rx_we, rx_re, tx_we, tx_re;

   assign rx_wr_nxt = (rx_wr_ff == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : rx_wr_ff + 1'b1;
   assign rx_rd_nxt = (rx_rd_ff == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : rx_rd_ff + 1'b1;
   assign tx_wr_nxt = (tx_wr_ff == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tx_wr_ff + 1'b1;
   assign tx_rd_nxt = (tx_rd_ff == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tx_rd_ff + 1'b1;

   assign rx_full  = (rx_wr_nxt == rx_rd_ff);
   assign rx_empty = (rx_wr_ff == rx_rd_ff);
   assign tx_full  = (tx_wr_nxt == tx_rd_ff);
   assign tx_empty = (tx_wr_ff == tx_rd_ff);

   always_comb begin
      rx_wr_in    = rx_wr_ff;
      rx_rd_in    = rx_rd_ff;
      tx_wr_in    = tx_wr_ff;
      tx_rd_in    = tx_rd_ff;
      last_err_in = last_err_ff;
      tx_en_in    = tx_en_ff;
      rx_we       = 1'b0;
      rx_re       = 1'b0;
      tx_we       = 1'b0;
      tx_re       = 1'b0;
      stage       = '0;

      case (req.cmd)
         CMD_LINE_RX: begin
            if (rx_full) begin
               last_err_in = ERR_OVERFLOW;
            end else begin
               rx_we       = 1'b1;
               rx_wr_in    = rx_wr_nxt;
               last_err_in = {1'b0, req.in_overrun, req.in_frame_error};
            end
         end
         CMD_READ: begin
            if (rx_empty) begin
               stage.rsp.no_data = 1'b1;
            end else begin
               rx_re                  = 1'b1;
               rx_rd_in               = rx_rd_nxt;
               stage.from_rx          = 1'b1;
               stage.rsp.byte_valid   = 1'b1;
               stage.rsp.err_frame    = last_err_ff[0];
               stage.rsp.err_overrun  = last_err_ff[1];
               stage.rsp.err_overflow = last_err_ff[2];
            end
         end
         CMD_PUT_START, CMD_QUEUE: begin
            if (!tx_full) begin
               tx_we              = 1'b1;
               tx_wr_in           = tx_wr_nxt;
               stage.rsp.accepted = 1'b1;
               if (req.cmd == CMD_PUT_START) begin
                  tx_en_in = 1'b1;
               end
            end
         end
         CMD_START_TX: begin
            tx_en_in = 1'b1;
         end
         CMD_LINE_READY: begin
            if (tx_en_ff) begin
               if (!tx_empty) begin
                  tx_re                = 1'b1;
                  tx_rd_in             = tx_rd_nxt;
                  stage.from_tx        = 1'b1;
                  stage.rsp.byte_valid = 1'b1;
               end else begin
                  tx_en_in = 1'b0;
               end
            end
         end
         CMD_FLUSH_RX: begin
            rx_wr_in = rx_rd_ff;
         end
         default: begin
         end
      endcase

      stage.rsp.rx_available = (rx_wr_in != rx_rd_in);
      stage.rsp.tx_pending   = (tx_wr_in != tx_rd_in);
      stage.rsp.tx_enabled   = tx_en_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_wr_ff    <= '0;
         rx_rd_ff    <= '0;
         tx_wr_ff    <= '0;
         tx_rd_ff    <= '0;
         last_err_ff <= ERR_NONE;
         tx_en_ff    <= 1'b1;
      end else if (accept) begin
         rx_wr_ff    <= rx_wr_in;
         rx_rd_ff    <= rx_rd_in;
         tx_wr_ff    <= tx_wr_in;
         tx_rd_ff    <= tx_rd_in;
         last_err_ff <= last_err_in;
         tx_en_ff    <= tx_en_in;
      end
   end

   urb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH), .ADDR_W(RX_PTR_W)) u_rx_ram (
      .clock   (clock),
      .wr_en   (accept && rx_we),
      .wr_addr (rx_wr_nxt),
      .wr_data (req.in_byte),
      .rd_en   (accept && rx_re),
      .rd_addr (rx_rd_nxt),
      .rd_data (rx_rdata)
   );

   urb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH), .ADDR_W(TX_PTR_W)) u_tx_ram (
      .clock   (clock),
      .wr_en   (accept && tx_we),
      .wr_addr (tx_wr_nxt),
      .wr_data (req.in_byte),
      .rd_en   (accept && tx_re),
      .rd_addr (tx_rd_nxt),
      .rd_data (tx_rdata)
   );

endmodule

/* hdl/uart_rx_tx_ring_buffers_unit.sv */
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers_unit
// receive and transmit ring buffers of a uart, one command per beat
// ----------------------------------------------------------------------------
//
//   channel  | ports                                 | beat carries
//   ---------+---------------------------------------+---------------------------
//   request  | req_valid, req_ready, req_payload     | command, byte, rx flags
//   response | rsp_valid, rsp_ready, rsp_payload     | byte, flags, ring status
//
// one beat is taken every cycle while the response side keeps up; each response
// passes through the middle stage, where the ring ram read port registers the byte,
// then the response register, which holds the beat until it is taken
// reset clears pointers, last error and response valid, and sets tx enable;
// ram contents are left as they are
// a stalled response holds back the middle stage, which then holds off req_ready
//
module uart_rx_tx_ring_buffers_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  urb_pkg::urb_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output urb_pkg::urb_rsp_type rsp_payload
);
   import urb_pkg::*;

   // middle stage: status decided at accept time, byte still in the ram register
   logic          s1_valid_ff, s1_valid_in;
   urb_stage_type s1_ff;
   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   urb_rsp_type   rsp_ff, rsp_in;

   urb_stage_type stage;
   logic [7:0]    rx_rdata, tx_rdata;
   logic          accept, rsp_free, s1_move;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && rsp_free;
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   urb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_payload),
      .stage    (stage),
      .rx_rdata (rx_rdata),
      .tx_rdata (tx_rdata)
   );

   // the ram output only changes on an accept, which cannot overtake s1
   always_comb begin
      rsp_in = s1_ff.rsp;
      if (s1_ff.from_rx) begin
         rsp_in.out_byte = rx_rdata;
      end else if (s1_ff.from_tx) begin
         rsp_in.out_byte = tx_rdata;
      end else begin
         rsp_in.out_byte = '0;
      end
   end

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !s1_move);
      rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= stage;
      end
      if (s1_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* tb/sv/uart_rx_tx_ring_buffers_unit_tb.sv */
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers_unit_tb
// self-checking bench for the uart receive and transmit ring buffer unit
// ----------------------------------------------------------------------------
// short command table first: empty and single-entry rings, extreme bytes and
// flags, every command
// then random bursts that fill and drain both rings past their limits
// a behavioural copy of the two rings predicts every response beat, checked
// field by field and in order
// both channels pause at random; once the response side holds off long enough
// to back up the request side
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers_unit_tb;

   import urb_pkg::*;

   // clocking and run length
   localparam int HALF_PERIOD  = 2;
   localparam int RESET_CYCLES = 6;
   localparam int ITEM_TARGET  = 1100;
   localparam int QUIET_FROM   = ITEM_TARGET - 150;  // no pauses from here on
   localparam int HOLD_AT      = 400;                // beats sent before the long hold-off
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_LIMIT  = 2000;
   localparam int SETTLE       = 12;
   localparam int LIMIT_CYCLES = 200000;

   // the one code the package leaves unnamed; the unit ignores it
   localparam logic [2:0] CMD_UNUSED = 3'd7;

   // bit positions within the remembered receive error
   localparam int ERR_FRAME_BIT    = 0;
   localparam int ERR_OVERRUN_BIT  = 1;
   localparam int ERR_OVERFLOW_BIT = 2;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   urb_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   urb_rsp_type rsp_payload;

   uart_rx_tx_ring_buffers_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // behavioural copy of both rings
   // each ring keeps one slot free, so a full ring holds depth-1 bytes
   // ------------------------------------------------------------------------
   logic [7:0] rx_ring [0:RX_DEPTH-1];
   logic [7:0] tx_ring [0:TX_DEPTH-1];
   int         rx_wr   = 0;
   int         rx_rd   = 0;
   int         tx_wr   = 0;
   int         tx_rd   = 0;
   logic [2:0] rx_err  = ERR_NONE;
   logic       tx_on   = 1'b1;

   function automatic int rx_next(int p);
      return (p + 1 >= RX_DEPTH) ? 0 : p + 1;
   endfunction

   function automatic int tx_next(int p);
      return (p + 1 >= TX_DEPTH) ? 0 : p + 1;
   endfunction

   // applies one command to the copy and returns the response it should give
   function automatic urb_rsp_type uart_rings_step(urb_req_type r);
      urb_rsp_type o;
      int          n;
      o = '0;
      case (r.cmd)
         CMD_LINE_RX: begin
            n = rx_next(rx_wr);
            if (n == rx_rd) begin
               // ring full: byte dropped, only the overflow is remembered
               rx_err = ERR_OVERFLOW;
            end else begin
               rx_ring[n] = r.in_byte;
               rx_wr      = n;
               rx_err     = ERR_NONE;
               rx_err[ERR_FRAME_BIT]   = r.in_frame_error;
               rx_err[ERR_OVERRUN_BIT] = r.in_overrun;
            end
         end
         CMD_READ: begin
            if (rx_wr == rx_rd) begin
               o.no_data = 1'b1;
            end else begin
               rx_rd          = rx_next(rx_rd);
               o.out_byte     = rx_ring[rx_rd];
               o.byte_valid   = 1'b1;
               o.err_frame    = rx_err[ERR_FRAME_BIT];
               o.err_overrun  = rx_err[ERR_OVERRUN_BIT];
               o.err_overflow = rx_err[ERR_OVERFLOW_BIT];
            end
         end
         CMD_PUT_START, CMD_QUEUE: begin
            n = tx_next(tx_wr);
            if (n != tx_rd) begin
               tx_ring[n] = r.in_byte;
               tx_wr      = n;
               o.accepted = 1'b1;
               if (r.cmd == CMD_PUT_START) begin
                  tx_on = 1'b1;
               end
            end
         end
         CMD_START_TX: begin
            tx_on = 1'b1;
         end
         CMD_LINE_READY: begin
            if (tx_on) begin
               if (tx_wr != tx_rd) begin
                  tx_rd        = tx_next(tx_rd);
                  o.out_byte   = tx_ring[tx_rd];
                  o.byte_valid = 1'b1;
               end else begin
                  // nothing left to send: line-ready handling switches off
                  tx_on = 1'b0;
               end
            end
         end
         CMD_FLUSH_RX: begin
            rx_wr = rx_rd;
         end
         default: begin
         end
      endcase
      o.rx_available = (rx_wr != rx_rd);
      o.tx_pending   = (tx_wr != tx_rd);
      o.tx_enabled   = tx_on;
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // response checking
   // ------------------------------------------------------------------------
   urb_rsp_type rsp_due[$];
   int          mismatches = 0;
   int          rsp_seen   = 0;
   int          items_sent = 0;
   bit          quiet      = 1'b0;

   task automatic report_mismatch(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
   endtask

   task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("response %0d field %s got %0h want %0h",
                                   rsp_seen, name, got, want));
      end
   endtask

   task automatic check_bit(string name, logic got, logic want);
      if (got !== want) begin
         report_mismatch($sformatf("response %0d field %s got %0b want %0b",
                                   rsp_seen, name, got, want));
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      urb_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_due.size() == 0) begin
            report_mismatch($sformatf("response %0d arrived with nothing outstanding",
                                      rsp_seen));
         end else begin
            want = rsp_due.pop_front();
            check_field("out_byte",   rsp_payload.out_byte,     want.out_byte);
            check_bit("byte_valid",   rsp_payload.byte_valid,   want.byte_valid);
            check_bit("no_data",      rsp_payload.no_data,      want.no_data);
            check_bit("err_frame",    rsp_payload.err_frame,    want.err_frame);
            check_bit("err_overrun",  rsp_payload.err_overrun,  want.err_overrun);
            check_bit("err_overflow", rsp_payload.err_overflow, want.err_overflow);
            check_bit("accepted",     rsp_payload.accepted,     want.accepted);
            check_bit("rx_available", rsp_payload.rx_available, want.rx_available);
            check_bit("tx_pending",   rsp_payload.tx_pending,   want.tx_pending);
            check_bit("tx_enabled",   rsp_payload.tx_enabled,   want.tx_enabled);
         end
         rsp_seen++;
      end
   end

   // ------------------------------------------------------------------------
   // response side: short random pauses, one long hold-off to back the unit up
   // ------------------------------------------------------------------------
   initial begin : rsp_side
      int  gap;
      bit  held;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (!held && items_sent >= HOLD_AT) begin
            // long stall while requests keep coming, so req_ready must drop
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   // offers one beat and waits for it to be taken; valid only drops for a pause
   task automatic offer(urb_req_type r, bit typed, urb_rsp_type typed_rsp);
      int          gap;
      urb_rsp_type predicted;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // the copy is always stepped, even where the row spells out the answer
      predicted = uart_rings_step(r);
      rsp_due.push_back(typed ? typed_rsp : predicted);
      if (r.cmd != CMD_UNUSED) begin
         items_sent++;
      end
      quiet = (items_sent >= QUIET_FROM);
   endtask

   // random byte and flags; they matter only to some commands but toggle anyway
   function automatic urb_req_type random_req(logic [2:0] cmd);
      urb_req_type r;
      r.cmd            = cmd;
      r.in_byte        = 8'($urandom_range(0, 255));
      r.in_frame_error = 1'($urandom_range(0, 1));
      r.in_overrun     = 1'($urandom_range(0, 1));
      return r;
   endfunction

   typedef struct {
      urb_req_type req;
      bit          typed;
      urb_rsp_type rsp;
   } cmd_row_type;

   cmd_row_type directed_rows[$];

   task automatic add_row(logic [2:0] cmd, logic [7:0] b, logic fe, logic dor,
                          bit typed, urb_rsp_type rsp);
      cmd_row_type row;
      row.req.cmd            = cmd;
      row.req.in_byte        = b;
      row.req.in_frame_error = fe;
      row.req.in_overrun     = dor;
      row.typed              = typed;
      row.rsp                = rsp;
      directed_rows.push_back(row);
   endtask

   initial begin : stimulus
      int kind;
      int n;
      int i;
      int waited;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table; typed responses read as
      // {out_byte, byte_valid, no_data, frame, overrun, overflow,
      //  accepted, rx_available, tx_pending, tx_enabled}
      // read straight after reset finds nothing
      add_row(CMD_READ, 8'h00, 1'b0, 1'b0, 1'b1,
              urb_rsp_type'{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1});
      // line ready on an empty ring switches tx off, then does nothing
      add_row(CMD_LINE_READY, 8'hFF, 1'b1, 1'b1, 1'b1,
              urb_rsp_type'{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
      add_row(CMD_LINE_READY, 8'h00, 1'b0, 1'b0, 1'b1,
              urb_rsp_type'{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
      add_row(CMD_START_TX, 8'h00, 1'b0, 1'b0, 1'b1,
              urb_rsp_type'{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1});
      // extreme line bytes, clean then with both flags
      add_row(CMD_LINE_RX, 8'h00, 1'b0, 1'b0, 1'b1,
              urb_rsp_type'{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1});
      add_row(CMD_LINE_RX, 8'hFF, 1'b1, 1'b1, 1'b1,
              urb_rsp_type'{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1});
      // reads carry the last error, not the error of the byte read
      add_row(CMD_READ, 8'h00, 1'b0, 1'b0, 1'b1,
              urb_rsp_type'{8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1});
      add_row(CMD_READ, 8'hFF, 1'b1, 1'b1, 1'b1,
              urb_rsp_type'{8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1});
      add_row(CMD_READ, 8'h00, 1'b0, 1'b0, 1'b1,
              urb_rsp_type'{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1});
      // single flags, then a flush of what they left behind
      add_row(CMD_LINE_RX, 8'hA5, 1'b1, 1'b0, 1'b0, '0);
      add_row(CMD_LINE_RX, 8'h5A, 1'b0, 1'b1, 1'b0, '0);
      add_row(CMD_FLUSH_RX, 8'h00, 1'b0, 1'b0, 1'b1,
              urb_rsp_type'{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1});
      add_row(CMD_READ, 8'hFF, 1'b1, 1'b1, 1'b1,
              urb_rsp_type'{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1});
      // transmit path: queue, put, an ignored code, send until empty
      add_row(CMD_QUEUE,      8'h00, 1'b1, 1'b1, 1'b0, '0);
      add_row(CMD_QUEUE,      8'hFF, 1'b0, 1'b0, 1'b0, '0);
      add_row(CMD_LINE_READY, 8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(CMD_PUT_START,  8'h3C, 1'b1, 1'b0, 1'b0, '0);
      add_row(CMD_UNUSED,     8'hFF, 1'b1, 1'b1, 1'b0, '0);
      add_row(CMD_LINE_READY, 8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(CMD_LINE_READY, 8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(CMD_LINE_READY, 8'h00, 1'b0, 1'b0, 1'b0, '0);
      // put and start re-enables after the ring ran dry
      add_row(CMD_PUT_START,  8'h81, 1'b0, 1'b1, 1'b0, '0);
      add_row(CMD_LINE_READY, 8'h00, 1'b0, 1'b0, 1'b0, '0);
      // a clean byte clears the remembered error
      add_row(CMD_LINE_RX,    8'h42, 1'b0, 1'b0, 1'b0, '0);
      add_row(CMD_READ,       8'h00, 1'b0, 1'b0, 1'b0, '0);

      foreach (directed_rows[k]) begin
         offer(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].rsp);
      end

      // random bursts; the long ones run a ring past full so the limits get hit
      while (items_sent < ITEM_TARGET) begin
         kind = $urandom_range(0, 9);
         n = ($urandom_range(0, 2) == 0) ? $urandom_range(60, 75) : $urandom_range(1, 40);
         if (kind < 4) begin
            // receive burst: mostly line bytes, then mostly reads
            for (i = 0; i < n; i++) begin
               offer(random_req(($urandom_range(0, 7) == 0) ? CMD_READ : CMD_LINE_RX),
                     1'b0, '0);
            end
            if ($urandom_range(0, 3) == 0) begin
               offer(random_req(CMD_FLUSH_RX), 1'b0, '0);
            end
            n = $urandom_range(1, 75);
            for (i = 0; i < n; i++) begin
               offer(random_req(($urandom_range(0, 9) == 0) ? CMD_LINE_RX : CMD_READ),
                     1'b0, '0);
            end
         end else if (kind < 8) begin
            // transmit burst: fill, maybe start, then line-ready ticks past empty
            if ($urandom_range(0, 1) == 0) begin
               offer(random_req(CMD_LINE_READY), 1'b0, '0);
            end
            for (i = 0; i < n; i++) begin
               offer(random_req(($urandom_range(0, 1) == 0) ? CMD_QUEUE : CMD_PUT_START),
                     1'b0, '0);
            end
            if ($urandom_range(0, 1) == 0) begin
               offer(random_req(CMD_START_TX), 1'b0, '0);
            end
            n = $urandom_range(1, 75);
            for (i = 0; i < n; i++) begin
               offer(random_req(($urandom_range(0, 9) == 0) ? CMD_QUEUE : CMD_LINE_READY),
                     1'b0, '0);
            end
         end else begin
            // any command at all, with the odd unused code as noise
            n = $urandom_range(10, 30);
            for (i = 0; i < n; i++) begin
               offer(random_req(($urandom_range(0, 49) == 0) ? CMD_UNUSED
                                                             : 3'($urandom_range(0, 6))),
                     1'b0, '0);
            end
         end
      end
      req_valid <= 1'b0;

      // drain, then a few more cycles to catch any stray beat
      waited = 0;
      while (rsp_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (rsp_due.size() != 0) begin
         report_mismatch($sformatf("%0d expected responses never arrived", rsp_due.size()));
      end
      repeat (SETTLE) @(posedge clock);

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #(LIMIT_CYCLES * 2 * HALF_PERIOD);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
